>>> hdl/gts_pkg.sv
package gts_pkg;

	// Sequencer geometry and field widths.
	localparam int NUM_COILS  = 10;
	localparam int TIME_BITS  = 24;
	localparam int GATE_W     = 11;
	localparam int COIL_W     = 10;
	localparam int GATE_IDX_W = 4;
	localparam int CAPT_W     = 24;
	localparam int SPEED_W    = 24;
	localparam int NUM_W      = 24;

	// Stage 0 is idle, stages 1 to NUM_COILS+1 wait for the matching gate.
	localparam int STAGE_W    = $clog2(NUM_COILS + 2);
	localparam int STEP_CNT_W = $clog2(NUM_W);

	// Stream widths, rounded up to whole bytes.
	localparam int S_DATA_W   = 16;
	localparam int M_DATA_W   = 72;

	localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(2500000);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DIVIDE
	} gts_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic div_start;
		logic div_step;
		logic move;
	} gts_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
	} gts_sts_t;

endpackage

>>> hdl/gate_timed_coil_sequencer.sv
// Coil sequencer timed by light gates. Each input item is one timer tick and
// gives exactly one result item. The block accepts a new tick in every cycle
// as long as results are drained; a result register and an output register
// sit between the two sides. The tick that reaches the final gate with a
// nonzero gap runs the restoring divider, which yields one quotient bit per
// cycle; no further tick is taken until the quotient is complete. The speed
// numerator may be written at any time the block is idle and takes effect
// on the next shot.
module gate_timed_coil_sequencer import gts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [0] ready_sensor, [1] trigger, [12:2] gate_levels, [15:13] zero
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [9:0] coil_drive, [10] capture_valid, [14:11] capture_gate,
	// [38:15] capture_time, [39] shot_done, [63:40] speed,
	// [64] speed_saturated, [71:65] zero
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_wr_en,
	input  logic [NUM_W-1:0]    cfg_wr_data
);

	gts_cmd_t              cmd;
	gts_sts_t              sts;
	logic [COIL_W-1:0]     coil_drive;
	logic                  capture_valid;
	logic [GATE_IDX_W-1:0] capture_gate;
	logic [CAPT_W-1:0]     capture_time;
	logic                  shot_done;
	logic [SPEED_W-1:0]    speed;
	logic                  speed_saturated;

	gts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gts_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.ready_sensor    (s_tdata[0]),
		.trigger         (s_tdata[1]),
		.gate_levels     (s_tdata[12:2]),
		.coil_drive      (coil_drive),
		.capture_valid   (capture_valid),
		.capture_gate    (capture_gate),
		.capture_time    (capture_time),
		.shot_done       (shot_done),
		.speed           (speed),
		.speed_saturated (speed_saturated)
	);

	// Pack the result fields, lowest field first.
	assign m_tdata = {7'b0, speed_saturated, speed, shot_done, capture_time,
		capture_gate, capture_valid, coil_drive};

	// At most one coil is ever driven.
	a_coil_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(coil_drive))
		else $error("more than one coil driven");

	// Saturation only comes with a finished shot and a full-scale speed.
	a_sat_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && speed_saturated) |-> (shot_done && (&speed)))
		else $error("speed saturated outside a finished shot");

	// Without a capture the capture fields are zero and no shot finishes.
	a_no_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !capture_valid) |->
		((capture_time == '0) && (capture_gate == '0) && !shot_done))
		else $error("capture fields set without a capture");

	// Speed is reported only with a finished shot.
	a_speed_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (speed != '0)) |-> shot_done)
		else $error("speed reported without a finished shot");

endmodule

>>> hdl/gts_div.sv
module gts_div import gts_pkg::*; (
	input  logic                 clk,
	input  logic                 start,
	input  logic                 step,
	input  logic [NUM_W-1:0]     numer,
	input  logic [TIME_BITS-1:0] denom,
	output logic [NUM_W-1:0]     quotient
);

	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] den_q;
	logic [NUM_W-1:0]     nq_q;
	logic [TIME_BITS:0]   trial;
	logic [TIME_BITS:0]   diff;
	logic                 ge;

	// One restoring step: bring down the next numerator bit and try the subtract.
	always_comb begin
		trial = {rem_q, nq_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// The numerator shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= denom;
			nq_q  <= numer;
		end else if (step) begin
			rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], ge};
		end
	end

	assign quotient = nq_q;

endmodule

>>> hdl/gts_dp.sv
module gts_dp import gts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gts_cmd_t              cmd,
	output gts_sts_t              sts,
	input  logic                  cfg_wr_en,
	input  logic [NUM_W-1:0]      cfg_wr_data,
	input  logic                  ready_sensor,
	input  logic                  trigger,
	input  logic [GATE_W-1:0]     gate_levels,
	output logic [COIL_W-1:0]     coil_drive,
	output logic                  capture_valid,
	output logic [GATE_IDX_W-1:0] capture_gate,
	output logic [CAPT_W-1:0]     capture_time,
	output logic                  shot_done,
	output logic [SPEED_W-1:0]    speed,
	output logic                  speed_saturated
);

	logic [NUM_W-1:0]      numer_q;
	logic [STAGE_W-1:0]    stage_q;
	logic [TIME_BITS-1:0]  tick_q;
	logic [TIME_BITS-1:0]  prev_q;

	logic [STAGE_W-1:0]    stage_n;
	logic [TIME_BITS-1:0]  tick_n;
	logic [TIME_BITS-1:0]  prev_n;
	logic [TIME_BITS-1:0]  tick_inc;
	logic [TIME_BITS-1:0]  gap;
	logic [STAGE_W-1:0]    gate_idx;
	logic [GATE_W-1:0]     gate_sh;
	logic                  hit;
	logic                  final_gate;
	logic [COIL_W-1:0]     coil_n;
	logic [NUM_W-1:0]      quo;

	logic [COIL_W-1:0]     res_coil_s1;
	logic                  res_cv_s1;
	logic [GATE_IDX_W-1:0] res_cg_s1;
	logic [CAPT_W-1:0]     res_ct_s1;
	logic                  res_done_s1;
	logic [SPEED_W-1:0]    res_speed_s1;
	logic                  res_sat_s1;
	logic                  res_div_s1;

	// Next sequencer state for the item on the input.
	always_comb begin
		stage_n    = stage_q;
		tick_n     = tick_q;
		prev_n     = prev_q;
		hit        = 1'b0;
		final_gate = 1'b0;
		tick_inc   = (&tick_q) ? tick_q : tick_q + 1'b1;
		gate_idx   = stage_q - 1'b1;
		gate_sh    = gate_levels >> gate_idx;
		gap        = tick_inc - prev_q;
		if (stage_q == '0) begin
			if (ready_sensor && trigger) begin
				stage_n = STAGE_W'(1);
				tick_n  = '0;
				prev_n  = '0;
			end
		end else begin
			tick_n = tick_inc;
			hit    = gate_sh[0];
			if (hit) begin
				prev_n = tick_inc;
				if (stage_q >= STAGE_W'(NUM_COILS + 1)) begin
					final_gate = 1'b1;
					stage_n    = '0;
				end else begin
					stage_n = stage_q + 1'b1;
				end
			end
		end
	end

	// One-hot coil enables for the stage after this item, all clear when idle or awaiting the final gate.
	always_comb begin
		for (int i = 0; i < COIL_W; i++) begin
			coil_n[i] = (i < NUM_COILS) && (stage_n == STAGE_W'(i + 1));
		end
	end

	// A final gate with a nonzero gap needs the divider.
	assign sts.need_div = final_gate && (gap != '0);

	// Configuration and sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numer_q <= NUM_RESET;
			stage_q <= '0;
			tick_q  <= '0;
			prev_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				numer_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				stage_q <= stage_n;
				tick_q  <= tick_n;
				prev_q  <= prev_n;
			end
		end
	end

	gts_div u_div (
		.clk      (clk),
		.start    (cmd.div_start),
		.step     (cmd.div_step),
		.numer    (numer_q),
		.denom    (gap),
		.quotient (quo)
	);

	// Result stage: filled when an item is taken, speed left to the divider if needed.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_coil_s1  <= coil_n;
			res_cv_s1    <= hit;
			res_cg_s1    <= hit ? GATE_IDX_W'(gate_idx) : '0;
			res_ct_s1    <= hit ? CAPT_W'(tick_inc) : '0;
			res_done_s1  <= final_gate;
			res_speed_s1 <= (final_gate && (gap == '0)) ? '1 : '0;
			res_sat_s1   <= final_gate && (gap == '0);
			res_div_s1   <= sts.need_div;
		end
	end

	// Output register, loaded from the result stage.
	always_ff @(posedge clk) begin
		if (cmd.move) begin
			coil_drive      <= res_coil_s1;
			capture_valid   <= res_cv_s1;
			capture_gate    <= res_cg_s1;
			capture_time    <= res_ct_s1;
			shot_done       <= res_done_s1;
			speed           <= res_div_s1 ? SPEED_W'(quo) : res_speed_s1;
			speed_saturated <= res_sat_s1;
		end
	end

endmodule

>>> hdl/gts_ctrl.sv
module gts_ctrl import gts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  gts_sts_t sts,
	output gts_cmd_t cmd
);

	gts_state_t            state_q;
	gts_state_t            state_n;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  res_vld_q;
	logic                  out_vld_q;
	logic                  move;
	logic                  accept;
	logic                  div_step;
	logic                  div_done;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands.
	always_comb begin
		move     = res_vld_q && (!out_vld_q || m_tready);
		state_n  = state_q;
		s_tready = 1'b0;
		div_step = 1'b0;
		div_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !res_vld_q || move;
				if (s_tvalid && s_tready && sts.need_div) begin
					state_n = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				div_step = 1'b1;
				if (cnt_q == STEP_CNT_W'(NUM_W - 1)) begin
					div_done = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
		accept        = s_tvalid && s_tready;
		cmd.accept    = accept;
		cmd.div_start = accept && sts.need_div;
		cmd.div_step  = div_step;
		cmd.move      = move;
	end

	// Step counter and the occupancy of the result and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			res_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept) begin
				res_vld_q <= !sts.need_div;
			end else if (div_done) begin
				res_vld_q <= 1'b1;
			end else if (move) begin
				res_vld_q <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb import gts_pkg::*; ();

	// Input item as packed into s_tdata, lowest field first.
	typedef struct packed {
		logic [S_DATA_W-GATE_W-3:0] pad;
		logic [GATE_W-1:0]          gates;
		logic                       trig;
		logic                       ready;
	} tick_item_t;

	// Result item as packed into m_tdata, lowest field first.
	typedef struct packed {
		logic [M_DATA_W-COIL_W-GATE_IDX_W-CAPT_W-SPEED_W-4:0] pad;
		logic                  sat;
		logic [SPEED_W-1:0]    speed;
		logic                  done;
		logic [CAPT_W-1:0]     ctime;
		logic [GATE_IDX_W-1:0] cgate;
		logic                  cvalid;
		logic [COIL_W-1:0]     coils;
	} tick_result_t;

	// Tracks the shot in progress and holds the results still owed by the block.
	class coil_shot_tracker;
		int unsigned            stage;
		logic [TIME_BITS-1:0]   tick_count;
		logic [TIME_BITS-1:0]   last_capture;
		logic [NUM_W-1:0]       numerator;
		tick_result_t           expected_results[$];
		int unsigned            faults;

		function new();
			stage        = 0;
			tick_count   = '0;
			last_capture = '0;
			numerator    = NUM_RESET;
			faults       = 0;
		endfunction

		function void set_numerator(logic [NUM_W-1:0] value);
			numerator = value;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		// Advances the shot by one accepted tick and queues the result it causes.
		function void note_tick(tick_item_t t);
			tick_result_t         r;
			logic [TIME_BITS-1:0] gap;
			longint unsigned      quotient;
			int unsigned          g;
			r = '0;
			if (stage == 0) begin
				if (t.ready && t.trig) begin
					stage        = 1;
					tick_count   = '0;
					last_capture = '0;
				end
			end else begin
				if (tick_count != {TIME_BITS{1'b1}})
					tick_count = tick_count + 1'b1;
				g = stage - 1;
				if (g < GATE_W && t.gates[g]) begin
					r.cvalid = 1'b1;
					r.cgate  = GATE_IDX_W'(g);
					r.ctime  = CAPT_W'(tick_count);
					if (stage >= NUM_COILS + 1) begin
						gap    = tick_count - last_capture;
						r.done = 1'b1;
						if (gap == '0) begin
							r.speed = {SPEED_W{1'b1}};
							r.sat   = 1'b1;
						end else begin
							quotient = longint'(numerator) / longint'(gap);
							if (quotient > {SPEED_W{1'b1}}) begin
								r.speed = {SPEED_W{1'b1}};
								r.sat   = 1'b1;
							end else begin
								r.speed = SPEED_W'(quotient);
							end
						end
						stage = 0;
					end else begin
						stage = stage + 1;
					end
					last_capture = tick_count;
				end
			end
			if (stage >= 1 && stage <= NUM_COILS)
				r.coils = COIL_W'(1) << (stage - 1);
			expected_results.push_back(r);
		endfunction

		// Compares one delivered result with the oldest one owed.
		function void check_result(tick_result_t act);
			tick_result_t exp_r;
			if (expected_results.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: unexpected item: coils %h cap %b/%0d/%0d",
						$realtime, act.coils, act.cvalid, act.cgate, act.ctime,
						"  done %b speed %0d sat %b", act.done, act.speed, act.sat);
				return;
			end
			exp_r = expected_results.pop_front();
			if (act.coils !== exp_r.coils || act.cvalid !== exp_r.cvalid ||
					act.cgate !== exp_r.cgate || act.ctime !== exp_r.ctime ||
					act.done !== exp_r.done || act.speed !== exp_r.speed ||
					act.sat !== exp_r.sat || act.pad !== exp_r.pad) begin
				faults++;
				if (faults <= 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected coils %h cap %b/%0d/%0d done %b",
						exp_r.coils, exp_r.cvalid, exp_r.cgate, exp_r.ctime, exp_r.done,
						"  speed %0d sat %b pad %h", exp_r.speed, exp_r.sat, exp_r.pad);
					$display("  actual   coils %h cap %b/%0d/%0d done %b",
						act.coils, act.cvalid, act.cgate, act.ctime, act.done,
						"  speed %0d sat %b pad %h", act.speed, act.sat, act.pad);
				end
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                cfg_wr_en = 1'b0;
	logic [NUM_W-1:0]    cfg_wr_data = '0;

	coil_shot_tracker    tracker = new();
	int unsigned         burst_left = 0;
	int unsigned         rx_mode = 0;
	int unsigned         rx_left = 0;
	int unsigned         rx_cycle = 0;
	logic                rx_ready;

	gate_timed_coil_sequencer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #10 clk = ~clk;

	// Receiver: switches among four stall patterns at random and checks each item.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 300);
		end else begin
			rx_left--;
		end
		rx_cycle++;
		case (rx_mode)
			0: rx_ready = 1'b1;
			1: rx_ready = 1'($urandom_range(0, 1));
			2: rx_ready = ($urandom_range(0, 3) == 0);
			default: rx_ready = (rx_cycle % 5 != 0);
		endcase
		m_tready <= rx_ready;
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(tick_result_t'(m_tdata));
	end

	// Hands one tick to the block, opening a fresh burst after a random gap, possibly none.
	task automatic send_tick(tick_item_t t);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_tick(t);
	endtask

	function automatic tick_item_t make_tick(logic ready, logic trig,
			logic [GATE_W-1:0] gates);
		tick_item_t t;
		t       = '0;
		t.ready = ready;
		t.trig  = trig;
		t.gates = gates;
		return t;
	endfunction

	// Random tick that mostly follows the shot: fires while idle, raises the awaited
	// gate at the given odds, and now and then sends pure noise.
	task automatic random_tick(int unsigned hit_odds);
		tick_item_t  t;
		int unsigned k;
		t       = '0;
		t.gates = GATE_W'($urandom_range(0, 2047));
		t.ready = 1'($urandom_range(0, 1));
		t.trig  = 1'($urandom_range(0, 1));
		k       = tracker.stage;
		if (k == 0) begin
			if ($urandom_range(0, 9) < 7) begin
				t.ready = 1'b1;
				t.trig  = 1'b1;
			end
		end else if ($urandom_range(0, 19) != 0) begin
			t.gates[k-1] = ($urandom_range(1, hit_odds) == 1);
		end
		send_tick(t);
	endtask

	// Random shots for a number of ticks, then the shot in progress is brought to its end.
	task automatic run_shots(int unsigned ticks);
		int unsigned odds;
		odds = 1;
		for (int unsigned i = 0; i < ticks; i++) begin
			if (tracker.stage == 0) begin
				case ($urandom_range(0, 3))
					0: odds = 1;
					1: odds = 2;
					2: odds = 4;
					default: odds = 12;
				endcase
			end
			random_tick(odds);
		end
		while (tracker.stage != 0)
			random_tick(1);
	endtask

	// Holds the sender until every owed result is in, then lets the block settle.
	task automatic drain_results();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_numerator(logic [NUM_W-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		tracker.set_numerator(value);
	endtask

	// Main sequence: reset, directed ticks, then random shots under several numerators.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Ready or trigger alone does not fire, and gates are ignored while idle.
		send_tick(make_tick(1'b1, 1'b0, 11'h7FF));
		send_tick(make_tick(1'b0, 1'b1, 11'h7FF));
		send_tick(make_tick(1'b0, 1'b0, 11'h000));
		// Fire, then every gate high: one stage per tick, ready and trigger ignored,
		// gap of one.
		send_tick(make_tick(1'b1, 1'b1, 11'h000));
		repeat (NUM_COILS + 1) send_tick(make_tick(1'b1, 1'b1, 11'h7FF));
		// Fire with gates high, miss the awaited gate, then walk the gates one at a time.
		send_tick(make_tick(1'b1, 1'b1, 11'h7FF));
		send_tick(make_tick(1'b0, 1'b0, 11'h7FE));
		while (tracker.stage != 0)
			send_tick(make_tick(1'b0, 1'b0, GATE_W'(1) << (tracker.stage - 1)));

		run_shots(380);
		write_numerator({NUM_W{1'b1}});
		run_shots(380);
		write_numerator(NUM_W'(1));
		run_shots(300);
		write_numerator('0);
		run_shots(250);
		write_numerator(NUM_W'($urandom_range(1, 16777215)));
		run_shots(350);
		write_numerator(NUM_RESET);
		run_shots(250);

		drain_results();
		repeat (10) @(posedge clk);
		if (tracker.faults == 0 && tracker.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog for a block that stops delivering.
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
hdl/gts_pkg.sv
hdl/gts_div.sv
hdl/gts_dp.sv
hdl/gts_ctrl.sv
hdl/gate_timed_coil_sequencer.sv
tb/tb.sv
